### hdl/rwu_pkg.sv
package rwu_pkg;

    // Field and datapath widths
    localparam int WIN_W   = 32;
    localparam int ACK_W   = 24;
    localparam int PKT_W   = 16;
    localparam int HALF_W  = 31;
    localparam int SUM_W   = WIN_W + 1;
    localparam int PROD_W  = SUM_W + PKT_W;
    localparam int CFG_IDX_W = 1;

    // Divider sizing: one quotient bit per step
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SSTHRESH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT      = 1'b1;

    // Configuration reset values
    localparam logic [WIN_W-1:0] SSTHRESH_RST = 32'd65535;
    localparam logic [PKT_W-1:0] PKT_RST      = 16'd1500;

    // Smallest suggested threshold
    localparam logic [HALF_W-1:0] HALF_MIN = 31'd2;

    typedef struct packed {
        logic start;
    } rwu_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rwu_div_sts_t;

endpackage

### hdl/reno_window_update_unit.sv
// Reno congestion window update, byte counted.
// Input channel: in_valid / in_stall with acked_bytes; one transaction is one ACK event.
// Output channel: out_valid / out_stall with window_bytes, suggested_threshold and
// in_slow_start; exactly one result transaction per ACK, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is the
// slow-start threshold, index 1 the packet size. cfg_ready is always high; write only
// while no ACK is in flight.
// Steps: an ACK consumed wholly by slow start goes from the slow-start step straight
// to the output, and one that needs no division passes the pending-credit check and
// the credit sum on its way. Otherwise the credit sum feeds one 33-step restoring
// division (one quotient bit per cycle in the divider), then a multiply and a saturating add.
// in_stall stays high from acceptance until the result is loaded into the output
// register, so one ACK is processed at a time; the division sets the rate.
// The output register lets the next ACK be accepted while a result waits. If the
// receiver stalls and a new result is ready, the sequencer holds it until the register
// frees up.
// Reset: window returns to INIT_WINDOW, credit to zero, registers to their defaults,
// output empty.
module reno_window_update_unit
#(
    parameter logic [31:0] INIT_WINDOW = 32'd15000
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rwu_pkg::ACK_W-1:0]     acked_bytes,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rwu_pkg::WIN_W-1:0]     window_bytes,
    output logic [rwu_pkg::HALF_W-1:0]    suggested_threshold,
    output logic                          in_slow_start,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rwu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rwu_pkg::WIN_W-1:0]     cfg_data
);
    import rwu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SS   = 3'd1;
    localparam logic [2:0] S_PEND = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_ADD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [WIN_W-1:0]  window_reg;
    logic [WIN_W-1:0]  window_next;
    logic [WIN_W-1:0]  credit_reg;
    logic [WIN_W-1:0]  credit_next;
    logic [WIN_W-1:0]  ssthresh_reg;
    logic [PKT_W-1:0]  pkt_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [ACK_W-1:0]  acked_reg;
    logic [ACK_W-1:0]  acked_next;
    logic [WIN_W-1:0]  divisor_reg;
    logic [WIN_W-1:0]  divisor_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  quot_reg;
    logic [SUM_W-1:0]  quot_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [WIN_W-1:0]  win_out_reg;
    logic [WIN_W-1:0]  win_out_next;
    logic [HALF_W-1:0] half_out_reg;
    logic [HALF_W-1:0] half_out_next;
    logic              ss_out_reg;
    logic              ss_out_next;

    logic [SUM_W-1:0]  grown;
    logic [SUM_W:0]    grown_diff;
    logic [SUM_W-1:0]  pend_sum;
    logic [PROD_W:0]   prod_sum;
    logic [WIN_W-1:0]  base_credit;
    logic              pend_hit;
    logic [HALF_W-1:0] half;

    rwu_div_ctl_t      div_ctl;
    rwu_div_sts_t      div_sts;
    logic [SUM_W-1:0]  div_quo;
    logic [WIN_W-1:0]  div_rem;

    rwu_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (sum_reg),
        .divisor   (divisor_reg),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Slow-start growth and leftover
    assign grown      = {1'b0, window_reg} + {{(SUM_W-ACK_W){1'b0}}, acked_reg};
    assign grown_diff = {1'b0, grown} - {2'b00, ssthresh_reg};

    // Pending credit and saturating adds
    assign pend_hit    = (credit_reg >= window_reg);
    assign base_credit = pend_hit ? '0 : credit_reg;
    assign pend_sum    = {1'b0, window_reg} + {{(SUM_W-PKT_W){1'b0}}, pkt_reg};
    assign prod_sum    = {{(PROD_W+1-WIN_W){1'b0}}, window_reg} + {1'b0, prod_reg};

    // Halved threshold of the final window
    assign half = (window_reg[WIN_W-1:1] < HALF_MIN) ? HALF_MIN : window_reg[WIN_W-1:1];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        credit_next    = credit_reg;
        out_valid_next = out_valid_reg;
        acked_next     = acked_reg;
        divisor_next   = divisor_reg;
        sum_next       = sum_reg;
        quot_next      = quot_reg;
        prod_next      = prod_reg;
        win_out_next   = win_out_reg;
        half_out_next  = half_out_reg;
        ss_out_next    = ss_out_reg;
        div_ctl.start  = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    acked_next = acked_bytes;
                    state_next = S_SS;
                end
            end
            S_SS:
            begin
                state_next = S_PEND;
                if (window_reg < ssthresh_reg)
                begin
                    if (grown_diff[SUM_W])
                    begin
                        // all bytes absorbed below the threshold
                        window_next = grown[WIN_W-1:0];
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        window_next = ssthresh_reg;
                        acked_next  = grown_diff[ACK_W-1:0];
                        if (grown_diff[ACK_W-1:0] == '0)
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_PEND:
            begin
                divisor_next = window_reg;
                sum_next     = {1'b0, base_credit} + {{(SUM_W-ACK_W){1'b0}}, acked_reg};
                if (pend_hit)
                begin
                    credit_next = '0;
                    window_next = pend_sum[WIN_W] ? '1 : pend_sum[WIN_W-1:0];
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((divisor_reg != '0) && (sum_reg >= {1'b0, divisor_reg}))
                begin
                    div_ctl.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    credit_next = sum_reg[WIN_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    credit_next = div_rem;
                    quot_next   = div_quo;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = quot_reg * pkt_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                window_next = (prod_sum[PROD_W:WIN_W] != '0) ? '1 : prod_sum[WIN_W-1:0];
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    win_out_next   = window_reg;
                    half_out_next  = half;
                    ss_out_next    = (window_reg < ssthresh_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= INIT_WINDOW;
            credit_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            credit_reg    <= credit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssthresh_reg <= SSTHRESH_RST;
            pkt_reg      <= PKT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SSTHRESH: ssthresh_reg <= cfg_data;
                CFG_PKT:      pkt_reg      <= cfg_data[PKT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acked_reg    <= acked_next;
        divisor_reg  <= divisor_next;
        sum_reg      <= sum_next;
        quot_reg     <= quot_next;
        prod_reg     <= prod_next;
        win_out_reg  <= win_out_next;
        half_out_reg <= half_out_next;
        ss_out_reg   <= ss_out_next;
    end

    assign in_stall            = (state_reg != S_IDLE);
    assign cfg_ready           = 1'b1;
    assign out_valid           = out_valid_reg;
    assign window_bytes        = win_out_reg;
    assign suggested_threshold = half_out_reg;
    assign in_slow_start       = ss_out_reg;

    // Checks
    a_start_in_chk: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> ((state_reg == S_CHK) && !div_sts.busy))
        else $error("divider started outside the check step");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DIV))
        else $error("divider finished while sequencer not waiting");

    a_accept_to_ss: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SS))
        else $error("accepted transaction did not enter slow-start step");

    a_half_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (suggested_threshold >= HALF_MIN))
        else $error("suggested threshold below floor");

endmodule

### hdl/rwu_div.sv
module rwu_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rwu_pkg::rwu_div_ctl_t     ctl,
    input  logic [rwu_pkg::SUM_W-1:0] dividend,
    input  logic [rwu_pkg::WIN_W-1:0] divisor,
    output rwu_pkg::rwu_div_sts_t     sts,
    output logic [rwu_pkg::SUM_W-1:0] quotient,
    output logic [rwu_pkg::WIN_W-1:0] remainder
);
    import rwu_pkg::*;

    logic [WIN_W-1:0]     rem_reg;
    logic [WIN_W-1:0]     rem_next;
    logic [SUM_W-1:0]     quo_reg;
    logic [SUM_W-1:0]     quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;

    logic [SUM_W-1:0]     trial;
    logic [SUM_W:0]       diff;

    // Restoring step: shift in next dividend bit, subtract when it fits
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[SUM_W])
            begin
                rem_next = diff[WIN_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIN_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### sim/tb_reno_window_update_unit.sv
module tb_reno_window_update_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rwu_pkg::*;

    localparam logic [WIN_W-1:0] INIT_CWND = 32'd15000;
    localparam logic [WIN_W-1:0] WIN_TOP   = 32'hFFFF_FFFF;
    localparam int MID_PHASES   = 7;
    localparam int MID_ACKS     = 110;
    localparam int CLIMB_ACKS   = 800;
    localparam int TAIL_ACKS    = 20;
    localparam int DRAIN_CYCLES = 60;

    typedef enum logic {ACK_MIXED, ACK_HEAVY} ack_profile_t;

    typedef struct packed {
        logic [WIN_W-1:0]  window;
        logic [HALF_W-1:0] half;
        logic              slow;
    } window_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ACK_W-1:0]     acked_bytes = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WIN_W-1:0]     window_bytes;
    logic [HALF_W-1:0]    suggested_threshold;
    logic                 in_slow_start;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SSTHRESH;
    logic [WIN_W-1:0]     cfg_data = '0;

    // Shadow of the congestion state and the two registers
    logic [WIN_W-1:0] cwnd_model = INIT_CWND;
    logic [WIN_W-1:0] credit_model = '0;
    logic [WIN_W-1:0] ssthresh_model = SSTHRESH_RST;
    logic [PKT_W-1:0] pkt_model = PKT_RST;

    logic [ACK_W-1:0] acks_to_send[$];
    window_result_t   window_results_due[$];
    int               mismatch_count = 0;
    bit               ack_taken = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_span = 0;
    int stall_style = 0;

    reno_window_update_unit #(.INIT_WINDOW(INIT_CWND)) uut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .acked_bytes         (acked_bytes),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .window_bytes        (window_bytes),
        .suggested_threshold (suggested_threshold),
        .in_slow_start       (in_slow_start),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [WIN_W-1:0] clamp_window(input logic [63:0] value);
        return (value > {32'd0, WIN_TOP}) ? WIN_TOP : value[WIN_W-1:0];
    endfunction

    // Apply one ACK to the shadow state and queue the result it should give
    task automatic advance_window(input logic [ACK_W-1:0] acked);
        logic [63:0]       left;
        logic [63:0]       sum;
        logic [63:0]       quot;
        logic [WIN_W-1:0]  capped;
        logic [WIN_W-1:0]  base;
        logic [WIN_W-1:0]  half;
        logic              keep_growing;
        window_result_t    res;

        left = {40'd0, acked};
        keep_growing = 1'b1;
        // slow start: grow towards the threshold, never past it
        if (cwnd_model < ssthresh_model)
        begin
            sum = {32'd0, cwnd_model} + left;
            capped = (sum < {32'd0, ssthresh_model}) ? sum[WIN_W-1:0] : ssthresh_model;
            left = left - {32'd0, capped - cwnd_model};
            cwnd_model = capped;
            keep_growing = (left != 0);
        end
        // congestion avoidance on whatever slow start left over
        if (keep_growing)
        begin
            base = cwnd_model;
            if (credit_model >= base)
            begin
                credit_model = '0;
                cwnd_model = clamp_window({32'd0, cwnd_model} + {48'd0, pkt_model});
            end
            sum = {32'd0, credit_model} + left;
            if (base != 0 && sum >= {32'd0, base})
            begin
                quot = sum / {32'd0, base};
                sum = sum - quot * {32'd0, base};
                credit_model = sum[WIN_W-1:0];
                cwnd_model = clamp_window({32'd0, cwnd_model} + quot * {48'd0, pkt_model});
            end
            else
            begin
                credit_model = sum[WIN_W-1:0];
            end
        end
        half = cwnd_model >> 1;
        res.window = cwnd_model;
        res.half = (half < {1'b0, HALF_MIN}) ? HALF_MIN : half[HALF_W-1:0];
        res.slow = (cwnd_model < ssthresh_model);
        window_results_due.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Both channels sampled at the rising edge; results checked before new ACKs
    always @(posedge clk)
    begin
        window_result_t due;
        ack_taken = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (window_results_due.size() == 0)
                report_mismatch("result transaction with none expected",
                                64'(window_bytes), 64'd0);
            else
            begin
                due = window_results_due.pop_front();
                if (window_bytes !== due.window)
                    report_mismatch("window_bytes", 64'(window_bytes), 64'(due.window));
                if (suggested_threshold !== due.half)
                    report_mismatch("suggested_threshold", 64'(suggested_threshold),
                                    64'(due.half));
                if (in_slow_start !== due.slow)
                    report_mismatch("in_slow_start", 64'(in_slow_start), 64'(due.slow));
            end
        end
        if (ack_taken)
            advance_window(acked_bytes);
    end

    // ACK sender: bursts of random length, random gaps after each burst
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || ack_taken))
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (acks_to_send.size() != 0)
            begin
                in_valid <= 1'b1;
                acked_bytes <= acks_to_send.pop_front();
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: stretches of no stall, light stall and heavy stall
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style = $urandom_range(0, 2);
            stall_span = $urandom_range(20, 400);
        end
        else
            stall_span--;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic logic [ACK_W-1:0] pick_acked(input ack_profile_t profile);
        if (profile == ACK_HEAVY && $urandom_range(0, 9) < 8)
            return ACK_W'($urandom_range(24'hE00000, 24'hFFFFFF));
        case ($urandom_range(0, 9))
            0, 1, 2: return ACK_W'($urandom_range(0, 255));
            3, 4, 5: return ACK_W'($urandom_range(0, 65535));
            6, 7:    return ACK_W'($urandom_range(0, 24'hFFFFF));
            default: return ACK_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    task automatic queue_acks(input int count, input ack_profile_t profile);
        repeat (count)
            acks_to_send.push_back(pick_acked(profile));
    endtask

    // Block is idle once every ACK is sent and every result has come back
    task automatic wait_quiet();
        while (acks_to_send.size() != 0 || in_valid || window_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                             input logic [WIN_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (reg_index == CFG_SSTHRESH)
            ssthresh_model = data;
        else
            pkt_model = data[PKT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [WIN_W-1:0] thresh, input logic [PKT_W-1:0] pkt);
        write_reg(CFG_SSTHRESH, thresh);
        write_reg(CFG_PKT, {16'd0, pkt});
    endtask

    // Reset, directed phases, random phases, final climb to the top of the range
    initial
    begin
        logic [WIN_W-1:0] thresh;
        logic [PKT_W-1:0] pkt;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: slow start from the initial window, one ACK landing exactly on
        // the threshold, then credit building and bulk increase
        acks_to_send = '{24'd0, 24'd1, 24'd1000, 24'd49534, 24'd0, 24'd100,
                         24'hFFFFFF, 24'h555555, 24'hAAAAAA};

        // threshold just above the window: slow start runs out, the rest carries on
        wait_quiet();
        set_config(cwnd_model + 32'd10, 16'd1);
        acks_to_send = '{24'hFFFFFF, 24'd1, 24'd0};

        // no slow start and zero packet size: credit still turns over
        wait_quiet();
        set_config(32'd0, 16'd0);
        acks_to_send = '{24'hFFFFFF, 24'hFFFFFF, 24'd12345};

        // largest packet size
        wait_quiet();
        set_config(32'd0, 16'hFFFF);
        acks_to_send = '{24'hFFFFFF, 24'h7FFFFF, 24'd0};

        repeat (MID_PHASES)
        begin
            wait_quiet();
            case ($urandom_range(0, 3))
                0: thresh = '0;
                1: thresh = $urandom_range(0, cwnd_model);
                default: thresh = clamp_window({32'd0, cwnd_model} + $urandom_range(1, 24'hFFFFFF));
            endcase
            case ($urandom_range(0, 3))
                0: pkt = 16'd1;
                1: pkt = 16'hFFFF;
                2: pkt = PKT_W'($urandom_range(1, 16'hFFFF));
                default: pkt = PKT_W'($urandom_range(500, 9000));
            endcase
            set_config(thresh, pkt);
            queue_acks(MID_ACKS, ACK_MIXED);
        end

        // long slow start to just under the top, then credit sums beyond 32 bits
        // and growth that saturates the window
        wait_quiet();
        set_config(WIN_TOP - $urandom_range(1, 4000), 16'hFFFF);
        queue_acks(CLIMB_ACKS, ACK_HEAVY);

        wait_quiet();
        set_config(WIN_TOP, PKT_W'($urandom_range(1, 16'hFFFF)));
        queue_acks(TAIL_ACKS, ACK_MIXED);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (window_results_due.size() != 0)
            report_mismatch("results still outstanding", 64'(window_results_due.size()),
                            64'd0);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(4_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
